@@ rtl/core/frs_pkg.sv @@
package frs_pkg;

    // Field widths fixed by the item formats.
    localparam int FITNESS_W  = 32;
    localparam int POSITION_W = 6;

    typedef logic signed [FITNESS_W-1:0] t_fitness;
    typedef logic [POSITION_W-1:0]       t_position;

    // One input beat.
    typedef struct packed {
        t_fitness fitness_value;
        logic     last_member;
    } t_in;

    // One result beat.
    typedef struct packed {
        t_position source_position;
        t_fitness  ranked_fitness;
        logic      final_rank;
    } t_out;

    // Contents of one sorting cell.
    typedef struct packed {
        logic      valid;
        t_fitness  fitness;
        t_position position;
    } t_entry;

    // Control broadcast to every cell in the chain.
    typedef struct packed {
        logic load;
        logic drain;
    } t_cell_ctl;

endpackage

@@ rtl/core/frs_cell.sv @@
module frs_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  frs_pkg::t_cell_ctl i_ctl,
    input  frs_pkg::t_entry    i_new,
    input  frs_pkg::t_entry    i_left,
    input  logic               i_left_push,
    input  frs_pkg::t_entry    i_right,
    output frs_pkg::t_entry    o_entry,
    output logic               o_push
);
    import frs_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // The new value goes in front of this cell when the cell is empty or holds a
    // strictly smaller value, so equal values keep their load order.
    assign o_push = !r_entry.valid || (i_new.fitness > r_entry.fitness);

    // On load, a pushed cell takes its left neighbor if that one is pushed too,
    // otherwise the new value lands here. On drain, everything moves left.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.drain) begin
            n_entry = i_right;
        end else if (i_ctl.load && o_push) begin
            n_entry = i_left_push ? i_left : i_new;
        end
    end

    // Only the valid bit needs a reset.
    always_ff @(posedge i_clk) begin
        r_entry.fitness  <= n_entry.fitness;
        r_entry.position <= n_entry.position;
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
    end

    assign o_entry = r_entry;

endmodule

@@ rtl/core/fitness_rank_sorter_core.sv @@
// Fitness rank sorter: ranks a population of signed fitness values, largest first.
// Input channel: a beat is taken at a rising edge where start is high and busy is low.
// Each beat carries one fitness value; last_member marks the end of the population.
// Loading runs at one beat per cycle: a chain of MAX_MEMBERS cells inserts each value
// in its sorted place in the same cycle, tagged with its load position.
// Beats beyond MAX_MEMBERS are dropped; a dropped beat marked last still starts output.
// Output channel: after the last beat, busy rises and the chain drains toward cell
// zero, one result per cycle, starting in the cycle right after the last beat.
// o_result_valid marks each result for exactly one cycle; final_rank marks the last.
// Busy stays high until the final result has been shown, then loading of a new population
// may begin at once. Equal values leave in load order.
// The receiver cannot stall the output; results must be taken as they appear.
// Synchronous reset empties the chain and returns the block to loading.
module fitness_rank_sorter_core #(
    parameter int MAX_MEMBERS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  frs_pkg::t_in  i_item,
    output logic          o_result_valid,
    output frs_pkg::t_out o_result
);
    import frs_pkg::*;

    localparam int CNT_W = $clog2(MAX_MEMBERS + 1);

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_remain;

    logic             accept;
    logic             room;
    logic [CNT_W-1:0] count_after;
    t_cell_ctl        cell_ctl;
    t_entry           new_entry;
    t_entry           entries [MAX_MEMBERS];
    logic             pushes  [MAX_MEMBERS];

    // Input handshake and overflow check.
    assign accept      = start && !busy;
    assign room        = (r_count < CNT_W'(MAX_MEMBERS));
    assign count_after = room ? (r_count + CNT_W'(1)) : r_count;

    assign cell_ctl.load  = accept && room;
    assign cell_ctl.drain = (r_state == ST_DRAIN);

    assign new_entry.valid    = 1'b1;
    assign new_entry.fitness  = i_item.fitness_value;
    assign new_entry.position = t_position'(r_count);

    // The insertion chain; cell zero holds the best value.
    for (genvar g = 0; g < MAX_MEMBERS; g++) begin : g_cell
        t_entry left_entry;
        t_entry right_entry;
        logic   left_push;

        if (g == 0) begin : g_head
            assign left_entry = '0;
            assign left_push  = 1'b0;
        end else begin : g_body
            assign left_entry = entries[g-1];
            assign left_push  = pushes[g-1];
        end

        if (g == MAX_MEMBERS - 1) begin : g_tail
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = entries[g+1];
        end

        frs_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_new       (new_entry),
            .i_left      (left_entry),
            .i_left_push (left_push),
            .i_right     (right_entry),
            .o_entry     (entries[g]),
            .o_push      (pushes[g])
        );
    end

    // Load counting and drain sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_count  <= '0;
            r_remain <= '0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (accept) begin
                        if (i_item.last_member) begin
                            r_state  <= ST_DRAIN;
                            r_remain <= count_after;
                            r_count  <= '0;
                        end else begin
                            r_count <= count_after;
                        end
                    end
                end
                ST_DRAIN: begin
                    r_remain <= r_remain - CNT_W'(1);
                    if (r_remain == CNT_W'(1)) begin
                        r_state <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign busy = (r_state == ST_DRAIN);

    // Results come straight from the registered head cell.
    assign o_result_valid           = (r_state == ST_DRAIN);
    assign o_result.source_position = entries[0].position;
    assign o_result.ranked_fitness  = entries[0].fitness;
    assign o_result.final_rank      = (r_remain == CNT_W'(1));

    // A last beat is followed by a result in the next cycle.
    a_last_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.last_member) |=> o_result_valid)
        else $error("last beat did not start output");

    // Every emitted result comes from an occupied head cell.
    a_head_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> entries[0].valid)
        else $error("result emitted from empty cell");

    // The final result ends the run and leaves the chain empty.
    a_final_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.final_rank) |=> (!busy && !entries[0].valid))
        else $error("run did not end after final result");

    // The drain count is never zero while draining.
    a_remain_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_remain != '0))
        else $error("drain count underflow");

endmodule

@@ sim/fitness_rank_sorter_core_tb.sv @@
`timescale 1ns / 1ps

module fitness_rank_sorter_core_tb;

    localparam int MAX_MEMBERS = 64;
    localparam int SETTLE_CYCLES = 2 * MAX_MEMBERS;

    // Value mixes used when building random populations.
    typedef enum int {
        MIX_WIDE,
        MIX_TIES,
        MIX_EDGES
    } t_value_mix;

    // One beat waiting to be sent, with its pacing hints.
    typedef struct {
        frs_pkg::t_in beat;
        bit           burst;
        bit           drain_first;
    } t_pending_member;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    frs_pkg::t_in  i_item = '0;
    logic          o_result_valid;
    frs_pkg::t_out o_result;

    t_pending_member     member_queue[$];
    frs_pkg::t_fitness   population_fit[$];
    frs_pkg::t_out       ranked_queue[$];

    int total_members = 0;
    int members_taken = 0;
    int ranks_due = 0;
    int ranks_seen = 0;
    int error_count = 0;
    int gap_left = 0;
    bit cur_burst = 1'b0;

    fitness_rank_sorter_core #(
        .MAX_MEMBERS(MAX_MEMBERS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_item(i_item),
        .o_result_valid(o_result_valid),
        .o_result(o_result)
    );

    always #4 i_clk = ~i_clk;

    // Records a failure; only the first few are described in detail.
    task automatic note_mismatch(input string what);
        if (error_count < 10) begin
            $display("%0t: %s", $time, what);
        end
        error_count++;
    endtask

    // Adds a beat to the population and, on the last member, ranks it.
    // Equal values keep their load order because only a strictly larger
    // value moves ahead of an earlier one.
    task automatic load_member(input frs_pkg::t_in beat);
        int order[$];
        int n;
        int cur;
        int j;
        frs_pkg::t_out rank;
        if (population_fit.size() < MAX_MEMBERS) begin
            population_fit.push_back(beat.fitness_value);
        end
        if (beat.last_member) begin
            n = population_fit.size();
            for (int i = 0; i < n; i++) begin
                order.push_back(i);
            end
            for (int i = 1; i < n; i++) begin
                cur = order[i];
                j = i;
                while (j > 0 && population_fit[order[j-1]] < population_fit[cur]) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = cur;
            end
            for (int i = 0; i < n; i++) begin
                rank.source_position = frs_pkg::t_position'(order[i]);
                rank.ranked_fitness  = population_fit[order[i]];
                rank.final_rank      = (i == n - 1);
                ranked_queue.push_back(rank);
                ranks_due++;
            end
            population_fit.delete();
        end
    endtask

    // Idle time after a beat: mostly none or short, now and then long.
    function automatic int pick_gap(input bit burst);
        int roll;
        roll = $urandom_range(0, 9);
        if (burst || roll < 5) begin
            return 0;
        end else if (roll < 8) begin
            return $urandom_range(1, 3);
        end else if (roll == 8) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic frs_pkg::t_fitness pick_fitness(input t_value_mix mix);
        case (mix)
            MIX_TIES: begin
                return frs_pkg::t_fitness'($urandom_range(0, 6)) - 3;
            end
            MIX_EDGES: begin
                case ($urandom_range(0, 5))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    3: return -32'sd1;
                    4: return 32'sd1;
                    default: return frs_pkg::t_fitness'($urandom);
                endcase
            end
            default: begin
                return frs_pkg::t_fitness'($urandom);
            end
        endcase
    endfunction

    task automatic add_member(input frs_pkg::t_fitness value, input bit last,
                              input bit burst, input bit drain_first);
        t_pending_member m;
        m.beat        = '{fitness_value: value, last_member: last};
        m.burst       = burst;
        m.drain_first = drain_first;
        member_queue.push_back(m);
        total_members++;
    endtask

    task automatic add_population(input int size, input bit drain_first);
        t_value_mix mix;
        bit burst;
        mix   = t_value_mix'($urandom_range(0, 2));
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < size; i++) begin
            add_member(pick_fitness(mix), i == size - 1, burst, drain_first && i == 0);
        end
    endtask

    // Driver: presents queued beats, holds them while busy, idles at random.
    always @(posedge i_clk) begin : drive_proc
        logic         next_start;
        frs_pkg::t_in next_item;
        if (!i_rst_n) begin
            start  <= 1'b0;
            i_item <= '0;
        end else begin
            next_start = start;
            next_item  = i_item;
            if (start && !busy) begin
                load_member(i_item);
                members_taken++;
                next_start = 1'b0;
                gap_left   = pick_gap(cur_burst);
            end
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (member_queue.size() > 0 &&
                             !(member_queue[0].drain_first && ranks_seen != ranks_due)) begin
                    next_item  = member_queue[0].beat;
                    cur_burst  = member_queue[0].burst;
                    next_start = 1'b1;
                    void'(member_queue.pop_front());
                end
            end
            start  <= next_start;
            i_item <= next_item;
        end
    end

    // Monitor: every strobed result must match the oldest ranked entry.
    always @(posedge i_clk) begin : watch_proc
        frs_pkg::t_out want;
        if (i_rst_n && o_result_valid) begin
            ranks_seen <= ranks_seen + 1;
            if (ranked_queue.size() == 0) begin
                note_mismatch($sformatf("unexpected result pos=%0d fit=%0d final=%0b",
                                        o_result.source_position,
                                        o_result.ranked_fitness, o_result.final_rank));
            end else begin
                want = ranked_queue.pop_front();
                if (o_result.source_position !== want.source_position ||
                    o_result.ranked_fitness !== want.ranked_fitness ||
                    o_result.final_rank !== want.final_rank) begin
                    note_mismatch($sformatf(
                        "rank mismatch: expected pos=%0d fit=%0d final=%0b, got pos=%0d fit=%0d final=%0b",
                        want.source_position, want.ranked_fitness, want.final_rank,
                        o_result.source_position, o_result.ranked_fitness,
                        o_result.final_rank));
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int roll;
        int pops;
        // Extremes, ties at both ends and stability of equal values.
        add_member(32'sh7FFF_FFFF, 1'b0, 1'b1, 1'b0);
        add_member(32'sh8000_0000, 1'b0, 1'b1, 1'b0);
        add_member(32'sd0, 1'b0, 1'b1, 1'b0);
        add_member(-32'sd1, 1'b0, 1'b1, 1'b0);
        add_member(32'sd1, 1'b0, 1'b1, 1'b0);
        add_member(32'sd7, 1'b0, 1'b1, 1'b0);
        add_member(32'sd7, 1'b0, 1'b1, 1'b0);
        add_member(-32'sd5, 1'b0, 1'b1, 1'b0);
        add_member(32'sh8000_0000, 1'b0, 1'b1, 1'b0);
        add_member(32'sh7FFF_FFFF, 1'b1, 1'b1, 1'b0);
        // Single-member populations, one sent only after the output has drained.
        add_member(32'sh8000_0000, 1'b1, 1'b0, 1'b1);
        add_member(32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b0);
        // Alternating bit patterns and an all-equal population.
        add_member(32'sh5555_5555, 1'b0, 1'b0, 1'b0);
        add_member(32'shAAAA_AAAA, 1'b0, 1'b0, 1'b0);
        add_member(32'sh7FFF_0000, 1'b1, 1'b0, 1'b0);
        add_member(32'sd3, 1'b0, 1'b0, 1'b1);
        add_member(32'sd3, 1'b0, 1'b0, 1'b0);
        add_member(32'sd3, 1'b1, 1'b0, 1'b0);

        // Overflow: the last member is dropped but still starts ranking.
        add_population(MAX_MEMBERS + 1, 1'b1);
        pops = 0;
        while (total_members < 300) begin
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
                add_population(1, pops % 4 == 0);
            end else if (roll < 15) begin
                add_population($urandom_range(2, 12), pops % 4 == 0);
            end else if (roll < 17) begin
                add_population($urandom_range(13, 40), pops % 4 == 0);
            end else if (roll == 17) begin
                add_population(MAX_MEMBERS, pops % 4 == 0);
            end else if (roll == 18) begin
                add_population($urandom_range(MAX_MEMBERS + 1, MAX_MEMBERS + 6), pops % 4 == 0);
            end else begin
                add_population(MAX_MEMBERS - 1, pops % 4 == 0);
            end
            pops++;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (members_taken < total_members) @(posedge i_clk);
        while (ranks_seen != ranks_due) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (ranked_queue.size() != 0) begin
            note_mismatch($sformatf("%0d ranked results never arrived", ranked_queue.size()));
        end
        if (error_count == 0) begin
            $display("fitness_rank_sorter_core_tb: clean");
        end else begin
            $display("fitness_rank_sorter_core_tb: errors");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("fitness_rank_sorter_core_tb: errors");
        $finish;
    end

endmodule

@@ fitness_rank_sorter_core.f @@
rtl/core/frs_pkg.sv
rtl/core/frs_cell.sv
rtl/core/fitness_rank_sorter_core.sv
sim/fitness_rank_sorter_core_tb.sv
